// ----- hdl/lwbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared types, codes and default sizes for the block cache directory.
// ----------------------------------------------------------------------------
package lwbc_pkg;

    // default sizes
    localparam int CACHE_SLOTS_DEF     = 16;
    localparam int SECTORS_PER_CYL_DEF = 32;
    localparam int BLOCK_BITS_DEF      = 16;

    // fixed field widths
    localparam int BLK_W   = 16;
    localparam int SLOT_W  = 4;
    localparam int CYL_W   = 11;
    localparam int SEC_W   = 5;
    localparam int STAMP_W = 32;

    // request codes on req_type
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BLK_W-1:0] blk;
    } entry_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot_index;
        logic              fetch_needed;
        logic [CYL_W-1:0]  fetch_cylinder;
        logic [SEC_W-1:0]  fetch_sector;
        logic              writeback_needed;
        logic [BLK_W-1:0]  writeback_block;
        logic [CYL_W-1:0]  writeback_cylinder;
        logic [SEC_W-1:0]  writeback_sector;
        logic              last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_FL_SCAN,
        S_FL_RD,
        S_CV1,
        S_CV2
    } back_state_t;

endpackage

// ----- hdl/lwbc_fifo.sv -----
// ----------------------------------------------------------------------------
// lwbc_fifo
// Two-entry queue of beats, used between front and back and on the results.
// ----------------------------------------------------------------------------
module lwbc_fifo
    import lwbc_pkg::*;
#(
    parameter type T = res_t
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    T           mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/lwbc_front.sv -----
// ----------------------------------------------------------------------------
// lwbc_front
// Accepts requests, decodes the type, masks the block and queues the work.
// ----------------------------------------------------------------------------
module lwbc_front
    import lwbc_pkg::*;
#(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       req_type,
    input  logic [BLK_W-1:0] block_number,
    output entry_t           q_entry,
    output logic             q_empty,
    input  logic             q_pop
);

    localparam int TAG_W = (BLOCK_BITS < BLK_W) ? BLOCK_BITS : BLK_W;

    entry_t                 entry;
    logic                   op_ok;
    logic [BLK_W+TAG_W-1:0] blk_ext;

    assign blk_ext = {{BLK_W{1'b0}}, block_number[TAG_W-1:0]};

    always_comb
    begin
        entry.blk = blk_ext[BLK_W-1:0];
        entry.op  = OP_READ;
        op_ok     = 1'b1;
        unique case (req_type)
            REQ_READ:  entry.op = OP_READ;
            REQ_WRITE: entry.op = OP_WRITE;
            REQ_FLUSH: entry.op = OP_FLUSH;
            default:   op_ok    = 1'b0;   // unused code: taken and dropped
        endcase
    end

    lwbc_fifo #(.T(entry_t)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && op_ok),
        .wr_data (entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_entry),
        .empty   (q_empty)
    );

endmodule

// ----- hdl/lwbc_conv.sv -----
// ----------------------------------------------------------------------------
// lwbc_conv
// Block to cylinder and sector, two-stage reciprocal multiply.
// ----------------------------------------------------------------------------
module lwbc_conv
    import lwbc_pkg::*;
#(
    parameter int SECTORS_PER_CYL = SECTORS_PER_CYL_DEF
)
(
    input  logic             clk,
    input  logic [BLK_W-1:0] blk_in,
    output logic [CYL_W-1:0] cyl,
    output logic [SEC_W-1:0] sec
);

    // ceil(2^K / D) with K = BLK_W + ceil(log2 D) is exact for every BLK_W-bit block
    localparam int          L_SH   = $clog2(SECTORS_PER_CYL);
    localparam int          K_SH   = BLK_W + L_SH;
    localparam int          D_W    = $clog2(SECTORS_PER_CYL + 1);
    localparam int          R_W    = BLK_W + 1;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << K_SH) + 64'(SECTORS_PER_CYL) - 64'd1) / 64'(SECTORS_PER_CYL);
    localparam logic [R_W-1:0] RECIP = RECIP64[R_W-1:0];
    localparam logic [D_W-1:0] DIVS  = D_W'(SECTORS_PER_CYL);

    logic [BLK_W+R_W-1:0] prod_reg;
    logic [BLK_W-1:0]     blk_d1_reg;
    logic [BLK_W-1:0]     q_reg;
    logic [BLK_W-1:0]     qd_reg;
    logic [BLK_W-1:0]     blk_d2_reg;
    logic [BLK_W+R_W-1:0] prod_sh;
    logic [BLK_W-1:0]     q;
    logic [BLK_W+D_W-1:0] qd_full;
    logic [BLK_W-1:0]     rem;
    logic [BLK_W+CYL_W-1:0] q_ext;

    assign prod_sh = prod_reg >> K_SH;
    assign q       = prod_sh[BLK_W-1:0];
    assign qd_full = {{D_W{1'b0}}, q} * {{BLK_W{1'b0}}, DIVS};
    assign rem     = blk_d2_reg - qd_reg;
    assign q_ext   = {{CYL_W{1'b0}}, q_reg};
    assign cyl     = q_ext[CYL_W-1:0];
    assign sec     = rem[SEC_W-1:0];

    always_ff @(posedge clk)
    begin
        prod_reg   <= {{R_W{1'b0}}, blk_in} * {{BLK_W{1'b0}}, RECIP};
        blk_d1_reg <= blk_in;
        q_reg      <= q;
        qd_reg     <= qd_full[BLK_W-1:0];
        blk_d2_reg <= blk_d1_reg;
    end

endmodule

// ----- hdl/lwbc_back.sv -----
// ----------------------------------------------------------------------------
// lwbc_back
// Slot directory: tag and stamp memories, LRU scan, update and flush walk.
// ----------------------------------------------------------------------------
module lwbc_back
    import lwbc_pkg::*;
#(
    parameter int CACHE_SLOTS     = CACHE_SLOTS_DEF,
    parameter int SECTORS_PER_CYL = SECTORS_PER_CYL_DEF,
    parameter int BLOCK_BITS      = BLOCK_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  entry_t q_entry,
    input  logic   q_empty,
    output logic   q_pop,
    output res_t   res,
    input  logic   res_full,
    output logic   res_push
);

    localparam int TAG_W = (BLOCK_BITS < BLK_W) ? BLOCK_BITS : BLK_W;
    localparam int IW    = $clog2(CACHE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_SLOTS - 1);

    back_state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic [TAG_W-1:0]   tag_mem   [CACHE_SLOTS];
    logic [STAMP_W-1:0] stamp_mem [CACHE_SLOTS];
    logic [TAG_W-1:0]   tag_rd_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;

    logic [CACHE_SLOTS-1:0] valid_reg;
    logic [CACHE_SLOTS-1:0] dirty_reg;
    logic [STAMP_W-1:0]     counter_reg;

    logic [TAG_W-1:0]   blk_reg;
    logic               is_flush_reg;
    logic               is_write_reg;
    logic               cmp_on_reg;
    logic [IW-1:0]      cmp_idx_reg;
    logic               hit_found_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [STAMP_W-1:0] best_reg;
    logic [IW-1:0]      victim_reg;
    logic [TAG_W-1:0]   victim_tag_reg;

    logic               res_hit_reg;
    logic [IW-1:0]      res_slot_reg;
    logic               res_fetch_reg;
    logic               res_wb_reg;
    logic [CYL_W-1:0]   fcyl_reg;
    logic [SEC_W-1:0]   fsec_reg;

    logic               start_rw;
    logic               start_fl;
    logic               do_update;
    logic               emit;
    logic [CACHE_SLOTS-1:0] vd;
    logic               any_from;
    logic               any_above;
    logic [IW-1:0]      upd_slot;
    logic               cmp_valid;
    logic               cmp_match;
    logic [STAMP_W-1:0] cmp_stamp;
    logic [TAG_W-1:0]   wtag;
    logic [BLK_W-1:0]   conv_in;
    logic [BLK_W+TAG_W-1:0] wtag_ext;
    logic [BLK_W+TAG_W-1:0] blk_ext;
    logic [CYL_W-1:0]   conv_cyl;
    logic [SEC_W-1:0]   conv_sec;
    logic [IW-1:0]      out_slot;
    logic [IW+SLOT_W-1:0] slot_ext;

    assign vd = valid_reg & dirty_reg;

    // dirty slots at or above the walk position, and strictly above it
    always_comb
    begin
        any_from  = 1'b0;
        any_above = 1'b0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (vd[i] && (IW'(i) >= idx_reg))
            begin
                any_from = 1'b1;
            end
            if (vd[i] && (IW'(i) > idx_reg))
            begin
                any_above = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_entry.op == OP_FLUSH) ? S_FL_SCAN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:   state_next = S_UPDATE;
            S_UPDATE:  state_next = S_CV1;
            S_FL_SCAN:
            begin
                if (!any_from)
                begin
                    state_next = S_IDLE;
                end
                else if (vd[idx_reg])
                begin
                    state_next = S_FL_RD;
                end
            end
            S_FL_RD:   state_next = S_CV1;
            S_CV1:     state_next = S_CV2;
            S_CV2:
            begin
                if (!res_full)
                begin
                    state_next = (is_flush_reg && any_above) ? S_FL_SCAN : S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop     = 1'b0;
        start_rw  = 1'b0;
        start_fl  = 1'b0;
        do_update = 1'b0;
        emit      = 1'b0;
        idx_next  = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    start_rw = (q_entry.op != OP_FLUSH);
                    start_fl = (q_entry.op == OP_FLUSH);
                end
            end
            S_SCAN:
            begin
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_UPDATE:  do_update = 1'b1;
            S_FL_SCAN:
            begin
                if (any_from && !vd[idx_reg])
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CV2:
            begin
                if (!res_full)
                begin
                    emit = 1'b1;
                    if (is_flush_reg && any_above)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:   ;
        endcase
    end

    assign res_push = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            cmp_on_reg  <= 1'b0;
            valid_reg   <= '0;
            dirty_reg   <= '0;
            counter_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cmp_on_reg <= (state_reg == S_SCAN);
            if (start_rw && (counter_reg != {STAMP_W{1'b1}}))
            begin
                counter_reg <= counter_reg + 1'b1;
            end
            if (do_update)
            begin
                valid_reg[upd_slot] <= 1'b1;
                dirty_reg[upd_slot] <= is_write_reg || (hit_found_reg && dirty_reg[upd_slot]);
            end
            if (emit && is_flush_reg)
            begin
                dirty_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // directory memories, registered read at the walk position
    assign upd_slot = hit_found_reg ? hit_idx_reg : victim_reg;

    always_ff @(posedge clk)
    begin
        tag_rd_reg   <= tag_mem[idx_reg];
        stamp_rd_reg <= stamp_mem[idx_reg];
        if (do_update)
        begin
            stamp_mem[upd_slot] <= counter_reg;
            if (!hit_found_reg)
            begin
                tag_mem[upd_slot] <= blk_reg;
            end
        end
    end

    // compare stage: the read data of the slot issued in the previous cycle
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign cmp_match = cmp_valid && (tag_rd_reg == blk_reg);
    assign cmp_stamp = cmp_valid ? stamp_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= idx_reg;
        if (start_rw || start_fl)
        begin
            blk_reg      <= q_entry.blk[TAG_W-1:0];
            is_flush_reg <= start_fl;
            is_write_reg <= (q_entry.op == OP_WRITE);
        end
        if (cmp_on_reg)
        begin
            if (cmp_idx_reg == '0)
            begin
                hit_found_reg  <= cmp_match;
                hit_idx_reg    <= '0;
                best_reg       <= cmp_stamp;
                victim_reg     <= '0;
                victim_tag_reg <= tag_rd_reg;
            end
            else
            begin
                if (cmp_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= cmp_idx_reg;
                end
                // strict compare keeps the lowest index on a tie
                if (cmp_stamp < best_reg)
                begin
                    best_reg       <= cmp_stamp;
                    victim_reg     <= cmp_idx_reg;
                    victim_tag_reg <= tag_rd_reg;
                end
            end
        end
        if (do_update)
        begin
            res_hit_reg   <= hit_found_reg;
            res_slot_reg  <= upd_slot;
            res_fetch_reg <= !hit_found_reg && !is_write_reg;
            res_wb_reg    <= !hit_found_reg && valid_reg[victim_reg] && dirty_reg[victim_reg];
            fcyl_reg      <= conv_cyl;
            fsec_reg      <= conv_sec;
        end
    end

    // converter sees the request block through the scan, then the write-back tag
    assign wtag     = is_flush_reg ? tag_rd_reg : victim_tag_reg;
    assign wtag_ext = {{BLK_W{1'b0}}, wtag};
    assign blk_ext  = {{BLK_W{1'b0}}, blk_reg};
    assign conv_in  = ((state_reg == S_UPDATE) || (state_reg == S_FL_RD) ||
                       (state_reg == S_CV1) || (state_reg == S_CV2)) ?
                      wtag_ext[BLK_W-1:0] : blk_ext[BLK_W-1:0];

    lwbc_conv #(.SECTORS_PER_CYL(SECTORS_PER_CYL)) u_conv (
        .clk    (clk),
        .blk_in (conv_in),
        .cyl    (conv_cyl),
        .sec    (conv_sec)
    );

    assign out_slot = is_flush_reg ? idx_reg : res_slot_reg;
    assign slot_ext = {{SLOT_W{1'b0}}, out_slot};

    always_comb
    begin
        res.hit                = !is_flush_reg && res_hit_reg;
        res.slot_index         = slot_ext[SLOT_W-1:0];
        res.fetch_needed       = !is_flush_reg && res_fetch_reg;
        res.fetch_cylinder     = is_flush_reg ? '0 : fcyl_reg;
        res.fetch_sector       = is_flush_reg ? '0 : fsec_reg;
        res.writeback_needed   = is_flush_reg || res_wb_reg;
        res.writeback_block    = res.writeback_needed ? wtag_ext[BLK_W-1:0] : '0;
        res.writeback_cylinder = res.writeback_needed ? conv_cyl : '0;
        res.writeback_sector   = res.writeback_needed ? conv_sec : '0;
        res.last               = !is_flush_reg || !any_above;
    end

endmodule

// ----- hdl/lru_write_back_block_cache.sv -----
// ----------------------------------------------------------------------------
// lru_write_back_block_cache
// Fully associative LRU write-back block cache directory.
// ----------------------------------------------------------------------------
// A read or write request walks the directory's tag and stamp memory one
// slot per cycle through a single registered read port, then updates the
// slot and runs the cylinder/sector multiply for the write-back address.
// A flush walks the slots, stopping after the last dirty one, and reports
// each dirty slot it writes back as a result. Requests and results each
// pass through a two-beat queue, so a request may be pushed while results
// wait to be popped. Request type 3 is taken and ignored. Valid and dirty
// bits clear at reset; there is no clearing pass.
module lru_write_back_block_cache
    import lwbc_pkg::*;
#(
    parameter int CACHE_SLOTS     = CACHE_SLOTS_DEF,
    parameter int SECTORS_PER_CYL = SECTORS_PER_CYL_DEF,
    parameter int BLOCK_BITS      = BLOCK_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       req_type,
    input  logic [BLK_W-1:0] block_number,
    output logic             empty,
    input  logic             pop,
    output logic             hit,
    output logic [SLOT_W-1:0] slot_index,
    output logic             fetch_needed,
    output logic [CYL_W-1:0] fetch_cylinder,
    output logic [SEC_W-1:0] fetch_sector,
    output logic             writeback_needed,
    output logic [BLK_W-1:0] writeback_block,
    output logic [CYL_W-1:0] writeback_cylinder,
    output logic [SEC_W-1:0] writeback_sector,
    output logic             last
);

    entry_t q_entry;
    logic   q_empty;
    logic   q_pop;
    res_t   res_in;
    res_t   res_out;
    logic   res_full;
    logic   res_push;

    lwbc_front #(.BLOCK_BITS(BLOCK_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .block_number (block_number),
        .q_entry      (q_entry),
        .q_empty      (q_empty),
        .q_pop        (q_pop)
    );

    lwbc_back #(
        .CACHE_SLOTS     (CACHE_SLOTS),
        .SECTORS_PER_CYL (SECTORS_PER_CYL),
        .BLOCK_BITS      (BLOCK_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_entry  (q_entry),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .res      (res_in),
        .res_full (res_full),
        .res_push (res_push)
    );

    lwbc_fifo #(.T(res_t)) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign hit                = res_out.hit;
    assign slot_index         = res_out.slot_index;
    assign fetch_needed       = res_out.fetch_needed;
    assign fetch_cylinder     = res_out.fetch_cylinder;
    assign fetch_sector       = res_out.fetch_sector;
    assign writeback_needed   = res_out.writeback_needed;
    assign writeback_block    = res_out.writeback_block;
    assign writeback_cylinder = res_out.writeback_cylinder;
    assign writeback_sector   = res_out.writeback_sector;
    assign last               = res_out.last;

`ifndef SYNTH
    // a fetch only follows a miss
    a_fetch_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && fetch_needed) |-> !hit)
        else $error("fetch requested on a hit");

    // a hit never evicts
    a_no_wb_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && hit) |-> !writeback_needed)
        else $error("write-back reported on a hit");

    // write-back address fields are zero when nothing is written back
    a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !writeback_needed) |->
            (writeback_block == '0 && writeback_cylinder == '0 &&
             writeback_sector == '0))
        else $error("write-back address set without write-back");

    // a flush beat carries no fetch
    a_flush_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && writeback_needed && !last) |-> (!fetch_needed && !hit))
        else $error("non-final flush beat with fetch or hit");
`endif

endmodule
